// ----- src/tcce_pkg.sv -----
// Shared constants and types for the text console cursor engine.
package tcce_pkg;

  // Default screen geometry and tab spacing
  localparam int unsigned COLUMNS_DEF  = 80;
  localparam int unsigned ROWS_DEF     = 25;
  localparam int unsigned TAB_STOP_DEF = 8;

  // Control bytes with special meaning
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;

  // Port widths of the request and result fields
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COLOR_W = 4;
  localparam int unsigned LINES_W = 5;
  localparam int unsigned ADDR_W  = 11;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned CELL_W  = 16;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 2'd0,
    OP_SCROLL = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

endpackage

// ----- src/text_console_cursor_engine_top.sv -----
// Text console engine: cell memory with cursor, scroll, clear and cell read.
//
// The screen lives in one ROWS x COLUMNS memory of 16-bit cell words (attribute in the
// upper byte, character in the lower byte) with one write port and one registered read
// port; the cursor, its tab phase and a small sequencer sit in flip-flops. After reset the
// block sweeps zeros through all ROWS*COLUMNS cells (2000 at 80x25), one cell a cycle, with
// in_ready_o low. A put request that stays on the screen is done in ST_IDLE, and a read
// request also passes through ST_READ, since the memory read is registered. A newline or
// wrap on the last row, a scroll by N > 0 and a clear are done by walking the memory one
// cell a cycle: a scroll copies (ROWS-N)*COLUMNS cells in a read-ahead pipeline and then
// blanks N*COLUMNS cells; a clear zeroes ROWS*COLUMNS cells. One request is worked on at
// a time; a result waits in an output register, and the next request is taken while it
// waits, up to the point where its own result is due.
module text_console_cursor_engine_top
  import tcce_pkg::*;
#(
  parameter int unsigned COLUMNS  = COLUMNS_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned TAB_STOP = TAB_STOP_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OP_W-1:0]    op_i,
  input  logic [BYTE_W-1:0]  char_byte_i,
  input  logic [COLOR_W-1:0] fg_color_i,
  input  logic [COLOR_W-1:0] bg_color_i,
  input  logic [LINES_W-1:0] scroll_lines_i,
  input  logic [ADDR_W-1:0]  read_addr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [POS_W-1:0]   cursor_pos_o,
  output logic [CELL_W-1:0]  read_data_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(CELLS + 1);
  localparam int unsigned AXW   = (CW > ADDR_W) ? CW : ADDR_W;
  localparam int unsigned CLW   = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned RW1   = $clog2(ROWS + 1);
  localparam int unsigned TW    = $clog2(TAB_STOP);
  localparam int unsigned NXW   = $clog2(COLUMNS + TAB_STOP);
  localparam int unsigned LXW   = (RW1 > LINES_W) ? RW1 : LINES_W;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_BLANK,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [CLW-1:0]      col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic [TW-1:0]       tab_q, tab_d;
  logic [CW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]       copy_rd_q, copy_rd_d;
  logic                copy_wv_q, copy_wv_d;
  logic                rd_ok_q, rd_ok_d;
  logic [CELL_W-1:0]   res_data_q, res_data_d;
  logic                out_valid_q, out_valid_d;
  logic [POS_W-1:0]    out_pos_q, out_pos_d;
  logic [CELL_W-1:0]   out_data_q, out_data_d;

  // Memory ports
  logic [CELL_W-1:0]   mem_q [CELLS];
  logic [CELL_W-1:0]   rdata_q;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [CELL_W-1:0]   mem_wd;
  logic [AW-1:0]       mem_ra;

  // Request decode helpers
  logic                accept;
  logic                out_free;
  logic [AXW-1:0]      addr_x;
  logic                addr_ok;
  logic [AW-1:0]       cur_idx;
  logic [NXW-1:0]      tab_next;
  logic [NXW-1:0]      col_inc;
  logic                is_nl;
  logic                is_tab;
  logic                wrap;
  logic                last_row;
  logic [RW1-1:0]      scroll_n;
  logic [RW1-1:0]      row_x;
  logic                fin;
  logic [CELL_W-1:0]   fin_data;
  logic [AW-1:0]       pos_full;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = out_pos_q;
  assign read_data_o  = out_data_q;

  assign addr_x   = AXW'(read_addr_i);
  assign addr_ok  = addr_x < AXW'(CELLS);
  assign cur_idx  = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign tab_next = NXW'(col_q) + NXW'(TAB_STOP) - NXW'(tab_q);
  assign col_inc  = NXW'(col_q) + NXW'(1);
  assign is_nl    = (char_byte_i == CHAR_NEWLINE);
  assign is_tab   = (char_byte_i == CHAR_TAB);
  assign last_row = (row_q == RW'(ROWS - 1));
  assign row_x    = RW1'(row_q);
  assign wrap     = is_nl
                 || (is_tab && (tab_next >= NXW'(COLUMNS)))
                 || (!is_nl && !is_tab && (col_inc == NXW'(COLUMNS)));

  // Saturate the scroll count at the screen height
  assign scroll_n = (LXW'(scroll_lines_i) > LXW'(ROWS)) ? RW1'(ROWS)
                                                        : RW1'(scroll_lines_i);

  // Next state, cursor update and memory port control
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    tab_d       = tab_q;
    wr_ptr_d    = wr_ptr_q;
    copy_rd_d   = copy_rd_q;
    copy_wv_d   = copy_wv_q;
    rd_ok_d     = rd_ok_q;
    res_data_d  = res_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_pos_d   = out_pos_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_wa      = wr_ptr_q[AW-1:0];
    mem_wd      = '0;
    mem_ra      = addr_x[AW-1:0];
    fin         = 1'b0;
    fin_data    = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(op_i))
            OP_PUT: begin
              // Store any byte other than newline and tab at the cursor
              if (!is_nl && !is_tab) begin
                mem_we = 1'b1;
                mem_wa = cur_idx;
                mem_wd = {bg_color_i, fg_color_i, char_byte_i};
              end
              if (wrap) begin
                col_d = '0;
                tab_d = '0;
                if (last_row) begin
                  // Scroll the whole screen up one row
                  copy_rd_d = CW'(COLUMNS);
                  copy_wv_d = 1'b0;
                  wr_ptr_d  = '0;
                  state_d   = ST_COPY;
                end else begin
                  row_d = row_q + RW'(1);
                  fin   = 1'b1;
                end
              end else if (is_tab) begin
                col_d = CLW'(tab_next);
                tab_d = '0;
                fin   = 1'b1;
              end else begin
                col_d = CLW'(col_inc);
                tab_d = (tab_q == TW'(TAB_STOP - 1)) ? '0 : tab_q + TW'(1);
                fin   = 1'b1;
              end
            end
            OP_SCROLL: begin
              if (scroll_n == '0) begin
                fin = 1'b1;
              end else begin
                row_d     = (row_x > scroll_n) ? RW'(row_x - scroll_n) : '0;
                copy_rd_d = CW'(scroll_n) * CW'(COLUMNS);
                copy_wv_d = 1'b0;
                wr_ptr_d  = '0;
                state_d   = ST_COPY;
              end
            end
            OP_CLEAR: begin
              col_d    = '0;
              row_d    = '0;
              tab_d    = '0;
              wr_ptr_d = '0;
              state_d  = ST_BLANK;
            end
            OP_READ: begin
              rd_ok_d = addr_ok;
              state_d = ST_READ;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        fin      = 1'b1;
        fin_data = rd_ok_q ? rdata_q : '0;
      end
      ST_COPY: begin
        // Write back the cell read last cycle, read ahead at the source
        mem_ra = copy_rd_q[AW-1:0];
        if (copy_wv_q) begin
          mem_we   = 1'b1;
          mem_wa   = wr_ptr_q[AW-1:0];
          mem_wd   = rdata_q;
          wr_ptr_d = wr_ptr_q + CW'(1);
        end
        if (copy_rd_q < CW'(CELLS)) begin
          copy_rd_d = copy_rd_q + CW'(1);
          copy_wv_d = 1'b1;
        end else begin
          copy_wv_d = 1'b0;
          if (!copy_wv_q) begin
            state_d = ST_BLANK;
          end
        end
      end
      ST_INIT, ST_BLANK: begin
        // Zero one cell a cycle up to the end of the screen
        mem_we = 1'b1;
        mem_wa = wr_ptr_q[AW-1:0];
        mem_wd = '0;
        if (wr_ptr_q == CW'(CELLS - 1)) begin
          if (state_q == ST_INIT) begin
            state_d = ST_IDLE;
          end else begin
            fin = 1'b1;
          end
        end else begin
          wr_ptr_d = wr_ptr_q + CW'(1);
        end
      end
      ST_DONE: begin
        fin      = 1'b1;
        fin_data = res_data_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Hand the result to the output register, or hold it until there is room
    pos_full = AW'(row_d) * AW'(COLUMNS) + AW'(col_d);
    if (fin) begin
      res_data_d = fin_data;
      if (out_free) begin
        out_valid_d = 1'b1;
        out_pos_d   = POS_W'(pos_full);
        out_data_d  = fin_data;
        state_d     = ST_IDLE;
      end else begin
        state_d = ST_DONE;
      end
    end
  end

  // Sequencer state, cursor and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      col_q       <= '0;
      row_q       <= '0;
      tab_q       <= '0;
      wr_ptr_q    <= '0;
      copy_rd_q   <= '0;
      copy_wv_q   <= 1'b0;
      rd_ok_q     <= 1'b0;
      res_data_q  <= '0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      tab_q       <= tab_d;
      wr_ptr_q    <= wr_ptr_d;
      copy_rd_q   <= copy_rd_d;
      copy_wv_q   <= copy_wv_d;
      rd_ok_q     <= rd_ok_d;
      res_data_q  <= res_data_d;
      out_valid_q <= out_valid_d;
      out_pos_q   <= out_pos_d;
      out_data_q  <= out_data_d;
    end
  end

  // Screen cell memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[mem_ra];
  end

`ifndef SYNTHESIS
  // Cursor stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < CLW'(COLUMNS - 1)) || (col_q == CLW'(COLUMNS - 1)))
    else $error("cursor column beyond row end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < RW'(ROWS - 1)) || (row_q == RW'(ROWS - 1)))
    else $error("cursor row beyond last row");

  // The copy source always runs ahead of the destination
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (copy_rd_q > wr_ptr_q))
    else $error("scroll copy source fell behind destination");

  // Blanking advances one cell per cycle until the end of the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_BLANK || state_q == ST_INIT) && (wr_ptr_q != CW'(CELLS - 1)))
    |=> (wr_ptr_q == $past(wr_ptr_q) + CW'(1)))
    else $error("blank sweep skipped or stalled");

  // No request is taken while a memory sweep is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY || state_q == ST_BLANK || state_q == ST_INIT) |-> !in_ready_o)
    else $error("request accepted during memory sweep");
`endif

endmodule

// ----- tb/text_console_cursor_engine_top_tb.sv -----
// Self-checking testbench for the text console cursor engine: screen model and random requests.
`timescale 1ns / 100ps

module text_console_cursor_engine_top_tb;
  import tcce_pkg::*;

  localparam int unsigned CELLS        = COLUMNS_DEF * ROWS_DEF;
  localparam int unsigned REQUESTS     = 1350;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned STALL_LIMIT  = 10000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 10;

  // Screen model: cell store, cursor and the queue of results still owed by the block
  class console_scoreboard;
    typedef struct {
      logic [POS_W-1:0]  pos;
      logic [CELL_W-1:0] data;
    } screen_result_t;

    logic [CELL_W-1:0] cells [CELLS];
    int unsigned col;
    int unsigned row;
    int unsigned errors;
    screen_result_t owed_q[$];

    function new();
      errors = 0;
      blank_all();
    endfunction

    function void blank_all();
      foreach (cells[i]) cells[i] = '0;
      col = 0;
      row = 0;
    endfunction

    function int unsigned cursor_linear();
      return row * COLUMNS_DEF + col;
    endfunction

    // Move rows up by the count, saturated at the screen height, and blank the freed rows
    function void scroll_rows(int unsigned lines);
      int unsigned n;
      n = (lines > ROWS_DEF) ? ROWS_DEF : lines;
      if (n == 0) return;
      for (int unsigned i = 0; i < CELLS; i++) begin
        cells[i] = (i + n * COLUMNS_DEF < CELLS) ? cells[i + n * COLUMNS_DEF] : '0;
      end
      row = (row > n) ? row - n : 0;
    endfunction

    function void next_row();
      col = 0;
      row++;
      if (row >= ROWS_DEF) scroll_rows(1);
    endfunction

    function void report(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", what);
    endfunction

    // Apply one accepted request and queue the result it owes
    function void note_request(op_e op, logic [BYTE_W-1:0] ch, logic [COLOR_W-1:0] fg,
                               logic [COLOR_W-1:0] bg, logic [LINES_W-1:0] lines,
                               logic [ADDR_W-1:0] addr);
      logic [CELL_W-1:0] data;
      int unsigned stop;
      data = '0;
      case (op)
        OP_PUT: begin
          if (ch == CHAR_NEWLINE) begin
            next_row();
          end else if (ch == CHAR_TAB) begin
            // tab always advances, wraps when it reaches the row end
            stop = (col / TAB_STOP_DEF + 1) * TAB_STOP_DEF;
            if (stop >= COLUMNS_DEF) next_row();
            else col = stop;
          end else begin
            cells[row * COLUMNS_DEF + col] = {bg, fg, ch};
            col++;
            if (col >= COLUMNS_DEF) next_row();
          end
        end
        OP_SCROLL: scroll_rows(lines);
        OP_CLEAR: blank_all();
        OP_READ: begin
          if (addr < CELLS) data = cells[addr];
        end
        default: begin
          data = '0;
        end
      endcase
      owed_q.push_back('{pos: POS_W'(cursor_linear()), data: data});
    endfunction

    // Compare one accepted result with the oldest owed one
    function void check_result(logic [POS_W-1:0] pos, logic [CELL_W-1:0] data);
      screen_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result: cursor_pos %0d read_data %h", pos, data));
        return;
      end
      want = owed_q.pop_front();
      if (pos !== want.pos || data !== want.data) begin
        report($sformatf("mismatch: cursor_pos exp %0d got %0d, read_data exp %h got %h",
                         want.pos, pos, want.data, data));
      end
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [OP_W-1:0]    op_i           = '0;
  logic [BYTE_W-1:0]  char_byte_i    = '0;
  logic [COLOR_W-1:0] fg_color_i     = '0;
  logic [COLOR_W-1:0] bg_color_i     = '0;
  logic [LINES_W-1:0] scroll_lines_i = '0;
  logic [ADDR_W-1:0]  read_addr_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b1;
  logic [POS_W-1:0]   cursor_pos_o;
  logic [CELL_W-1:0]  read_data_o;

  console_scoreboard board = new();
  bit          calm = 1'b0;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_stall = 0;

  text_console_cursor_engine_top DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .char_byte_i,
    .fg_color_i,
    .bg_color_i,
    .scroll_lines_i,
    .read_addr_i,
    .out_valid_o,
    .out_ready_i,
    .cursor_pos_o,
    .read_data_o
  );

  always #5 clk_i = ~clk_i;

  // Throttle the result side in random bursts unless the run is calm
  always @(negedge clk_i) begin
    if (calm) begin
      out_ready_i <= 1'b1;
      rx_stall = 0;
    end else if (rx_stall > 0) begin
      out_ready_i <= 1'b0;
      rx_stall--;
    end else if ($urandom_range(0, 6) == 0) begin
      out_ready_i <= 1'b0;
      rx_stall = $urandom_range(1, 11) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check accepted results and stop a hung run
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(cursor_pos_o, read_data_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one request, hold it until accepted, then note it in the model
  task automatic send_request(op_e op, logic [BYTE_W-1:0] ch, logic [COLOR_W-1:0] fg,
                              logic [COLOR_W-1:0] bg, logic [LINES_W-1:0] lines,
                              logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    char_byte_i    <= ch;
    fg_color_i     <= fg;
    bg_color_i     <= bg;
    scroll_lines_i <= lines;
    read_addr_i    <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(op, ch, fg, bg, lines, addr);
    sent++;
  endtask

  task automatic put_byte(logic [BYTE_W-1:0] ch);
    send_request(OP_PUT, ch, COLOR_W'($urandom), COLOR_W'($urandom), LINES_W'($urandom),
                 ADDR_W'($urandom));
  endtask

  task automatic read_cell(logic [ADDR_W-1:0] addr);
    send_request(OP_READ, BYTE_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                 LINES_W'($urandom), addr);
  endtask

  // Mostly cells just behind the cursor, sometimes anywhere in the address range
  function automatic logic [ADDR_W-1:0] near_addr();
    int pick;
    if ($urandom_range(0, 3) == 0) return ADDR_W'($urandom_range(0, 2047));
    pick = int'(board.cursor_linear()) - int'($urandom_range(0, 160));
    return (pick < 0) ? '0 : ADDR_W'(pick);
  endfunction

  function automatic logic [BYTE_W-1:0] text_byte();
    if ($urandom_range(0, 9) == 0) return BYTE_W'($urandom_range(0, 255));
    return BYTE_W'($urandom_range(8'h20, 8'h7E));
  endfunction

  initial begin
    int unsigned kind;
    int unsigned len;

    // Hold reset, then release it on a falling clock edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte and colour extremes, tab stops, wrap, scroll counts, read range
    calm = 1'b1;
    read_cell(11'd0);
    send_request(OP_PUT, 8'h41, 4'h0, 4'h0, 5'd0, 11'd0);
    send_request(OP_PUT, 8'hFF, 4'hF, 4'hF, 5'd31, 11'h7FF);
    send_request(OP_PUT, 8'h00, 4'h5, 4'hA, 5'd0, 11'd0);
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'd2);
    // tab from a column off a stop, then from a stop, then until the row end wraps
    repeat (10) put_byte(CHAR_TAB);
    put_byte(CHAR_NEWLINE);
    send_request(OP_SCROLL, 8'h00, 4'h0, 4'h0, 5'd0, 11'd0);
    send_request(OP_SCROLL, 8'h00, 4'h0, 4'h0, 5'd1, 11'd0);
    send_request(OP_SCROLL, 8'h00, 4'h0, 4'h0, 5'd31, 11'd0);
    read_cell(11'd1999);
    read_cell(11'd2000);
    read_cell(11'h7FF);
    send_request(OP_CLEAR, 8'hFF, 4'hF, 4'hF, 5'd31, 11'h7FF);

    // Random: sequences of text, newlines, tabs and reads, with rare scroll and clear
    while (sent < REQUESTS) begin
      calm = (sent + CALM_TAIL >= REQUESTS) || ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        len = $urandom_range(1, 40);
        repeat (len) send_request(OP_PUT, text_byte(), COLOR_W'($urandom),
                                  COLOR_W'($urandom), LINES_W'($urandom),
                                  ADDR_W'($urandom));
        len = $urandom_range(1, 3);
        repeat (len) read_cell(near_addr());
      end else if (kind < 55) begin
        len = $urandom_range(1, 8);
        repeat (len) read_cell(near_addr());
      end else if (kind < 67) begin
        // keep newline runs short on the last row, each one there scrolls the screen
        len = (board.row >= ROWS_DEF - 1) ? $urandom_range(1, 2) : $urandom_range(1, 12);
        repeat (len) begin
          put_byte(CHAR_NEWLINE);
          if ($urandom_range(0, 1) == 0) put_byte(text_byte());
        end
      end else if (kind < 77) begin
        len = $urandom_range(1, 10);
        repeat (len) begin
          put_byte(CHAR_TAB);
          if ($urandom_range(0, 2) == 0) put_byte(text_byte());
        end
      end else if (kind < 90) begin
        // noise: any byte or any address with arbitrary side fields
        if ($urandom_range(0, 1) == 0) begin
          send_request(OP_PUT, BYTE_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                       LINES_W'($urandom), ADDR_W'($urandom));
        end else begin
          send_request(OP_READ, BYTE_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                       LINES_W'($urandom), ADDR_W'($urandom));
        end
      end else if (kind < 97) begin
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4) : $urandom_range(0, 31);
        send_request(OP_SCROLL, BYTE_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                     LINES_W'(len), ADDR_W'($urandom));
        read_cell(near_addr());
      end else begin
        send_request(OP_CLEAR, BYTE_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                     LINES_W'($urandom), ADDR_W'($urandom));
        read_cell(near_addr());
      end
    end

    // Drop valid, wait for every owed result, then let the pipeline settle
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0 && board.owed_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- text_console_cursor_engine_top.f -----
src/tcce_pkg.sv
src/text_console_cursor_engine_top.sv
tb/text_console_cursor_engine_top_tb.sv
